[sv/tsta_pkg.sv]
// ----------------------------------------------------------------------------
// tsta_pkg
// Types, codes and helpers shared by the thread state time accounting unit.
// ----------------------------------------------------------------------------
package tsta_pkg;

  // slots reachable through the 4-bit slot field
  localparam int SLOT_LIMIT  = 16;
  localparam int NUM_TIMERS  = 6;
  localparam int NUM_DRAINED = 7;

  localparam logic [63:0] SIGNED_TOP64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // operation codes carried on the input channel
  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_SET_STATE  = 3'd1,
    OP_SET_SERIAL = 3'd2,
    OP_UPDATE     = 3'd3,
    OP_AGG_ALL    = 3'd4,
    OP_AGG_SUBSET = 3'd5
  } op_t;

  // command kinds after classification
  typedef enum logic [2:0] {
    K_NOP,
    K_REG,
    K_STATE,
    K_SERIAL,
    K_UPDATE,
    K_AGG_ALL,
    K_AGG_SUB
  } kind_t;

  // thread state codes
  localparam logic [2:0] TS_DISABLED = 3'd0;
  localparam logic [2:0] TS_USEFUL   = 3'd1;
  localparam logic [2:0] TS_MPI      = 3'd2;
  localparam logic [2:0] TS_OMPIN    = 3'd3;
  localparam logic [2:0] TS_OMPOUT   = 3'd4;
  localparam logic [2:0] TS_GPU      = 3'd5;

  // timer indexes within a slot row
  localparam logic [2:0] TM_USEFUL = 3'd0;
  localparam logic [2:0] TM_MPI    = 3'd1;
  localparam logic [2:0] TM_OMPMPI = 3'd2;
  localparam logic [2:0] TM_OMPIN  = 3'd3;
  localparam logic [2:0] TM_OMPOUT = 3'd4;
  localparam logic [2:0] TM_GPU    = 3'd5;
  localparam logic [2:0] TM_NONE   = 3'd7;

  // hardware counter indexes
  localparam logic HW_CYCLES = 1'b0;
  localparam logic HW_INSTR  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNREG = 2'd1;
  localparam logic [1:0] ST_OMPIN = 2'd2;

  // metric indexes
  localparam logic [3:0] M_USEFUL = 4'd0;
  localparam logic [3:0] M_LB     = 4'd7;
  localparam logic [3:0] M_SCHED  = 4'd8;
  localparam logic [3:0] M_CPUS   = 4'd9;

  // one slot row in the accounting memory
  typedef struct packed {
    logic [1:0][63:0] hw;
    logic [5:0][63:0] tm;
    logic [63:0]      last;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // classified command passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic        in_range;
    logic [2:0]  req_state;
    logic [62:0] timestamp;
    logic [31:0] cycles_delta;
    logic [31:0] instr_delta;
    logic        counters_valid;
    logic        serial_value;
    logic [15:0] slot_mask;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_URD,
    S_UADD,
    S_UWR,
    S_NOW,
    S_SCAN,
    S_ARD,
    S_AADV,
    S_AFIN,
    S_SCHED,
    S_EMIT,
    S_ONE
  } bstate_t;

  // timer charged while a slot sits in a state
  function automatic logic [2:0] timer_of(logic [2:0] st);
    logic [2:0] t;
    case (st)
      TS_USEFUL: t = TM_USEFUL;
      TS_MPI:    t = TM_MPI;
      TS_OMPIN:  t = TM_OMPIN;
      TS_OMPOUT: t = TM_OMPOUT;
      TS_GPU:    t = TM_GPU;
      default:   t = TM_NONE;
    endcase
    return t;
  endfunction

endpackage

[sv/thread_state_time_accounting_unit.sv]
// ----------------------------------------------------------------------------
// thread_state_time_accounting_unit
// Per-thread state residency accounting with aggregation over thread slots.
//
//   channel  direction  handshake            payload
//   in_      slave      tvalid/tready        tdata fields, tuser operation
//   out_     master     tvalid/tready/tlast  tdata status+value, tuser metric
//   cfg_     slave      APB psel/penable     hwc_enabled at byte address 0
//
// Register, set state, set serial mode and unknown operations act in dispatch,
// update after it; each row access goes through one memory port as read, adjust, write.
// Aggregate all walks the N slots once; aggregate subset walks them twice, first
// for the minimum, then to drain the P slots that take part.
// Reset is synchronous and clears control state; no memory clearing pass.
// A stalled output holds the sequencer; the front queue takes two more items.
// ----------------------------------------------------------------------------
module thread_state_time_accounting_unit #(
  parameter int MAX_THREADS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // slave stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // thread_slot[3:0], new_state[6:4], timestamp[69:7], cycles_delta[101:70],
  // instr_delta[133:102], counters_valid[134], serial_value[135],
  // slot_mask[151:136]
  input  logic [151:0] in_tdata,
  // operation[2:0]
  input  logic [2:0]   in_tuser,
  // master stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], metric_value[65:2], zero[71:66]
  output logic [71:0]  out_tdata,
  // metric_index[3:0]
  output logic [3:0]   out_tuser,
  output logic         out_tlast,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic           hwc_r;
  logic           q_valid, q_pop;
  tsta_pkg::cmd_t q_cmd;
  logic [1:0]     o_status;
  logic [63:0]    o_value;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwc_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == 1'b0) begin
      hwc_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, hwc_r} : 32'd0;

  tsta_front #(
    .MAX_THREADS (MAX_THREADS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  tsta_back #(
    .MAX_THREADS (MAX_THREADS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .hwc_enabled      (hwc_r),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (o_status),
    .out_metric_index (out_tuser),
    .out_metric_value (o_value),
    .out_last         (out_tlast)
  );

  assign out_tdata = {6'd0, o_value, o_status};

endmodule

[sv/tsta_ram.sv]
// ----------------------------------------------------------------------------
// tsta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/tsta_front.sv]
// ----------------------------------------------------------------------------
// tsta_front
// Accepts input transfers, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tsta_front #(
  parameter int MAX_THREADS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [151:0]          in_tdata,
  input  logic [2:0]            in_tuser,
  output logic                  q_valid,
  output tsta_pkg::cmd_t        q_cmd,
  input  logic                  q_pop
);

  localparam int NS = (MAX_THREADS < tsta_pkg::SLOT_LIMIT) ? MAX_THREADS
                                                             : tsta_pkg::SLOT_LIMIT;

  tsta_pkg::cmd_t cls;
  tsta_pkg::cmd_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push;

  // unpack and classify the incoming transfer
  always_comb begin
    cls.slot           = in_tdata[3:0];
    cls.req_state      = in_tdata[6:4];
    cls.timestamp      = in_tdata[69:7];
    cls.cycles_delta   = in_tdata[101:70];
    cls.instr_delta    = in_tdata[133:102];
    cls.counters_valid = in_tdata[134];
    cls.serial_value   = in_tdata[135];
    cls.slot_mask      = in_tdata[151:136];
    cls.in_range       = (5'(in_tdata[3:0]) < 5'(NS));
    case (in_tuser)
      tsta_pkg::OP_REGISTER:   cls.kind = tsta_pkg::K_REG;
      tsta_pkg::OP_SET_STATE:  cls.kind = tsta_pkg::K_STATE;
      tsta_pkg::OP_SET_SERIAL: cls.kind = tsta_pkg::K_SERIAL;
      tsta_pkg::OP_UPDATE:     cls.kind = tsta_pkg::K_UPDATE;
      tsta_pkg::OP_AGG_ALL:    cls.kind = tsta_pkg::K_AGG_ALL;
      tsta_pkg::OP_AGG_SUBSET: cls.kind = tsta_pkg::K_AGG_SUB;
      default:                 cls.kind = tsta_pkg::K_NOP;
    endcase
    // a full aggregate takes every slot
    if (in_tuser == tsta_pkg::OP_AGG_ALL) begin
      cls.slot_mask = 16'hFFFF;
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = ent_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[sv/tsta_back.sv]
// ----------------------------------------------------------------------------
// tsta_back
// Carries out classified commands on the slot state and emits result transfers.
// ----------------------------------------------------------------------------
module tsta_back #(
  parameter int MAX_THREADS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  hwc_enabled,
  input  logic                  q_valid,
  input  tsta_pkg::cmd_t        q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [1:0]            out_status,
  output logic [3:0]            out_metric_index,
  output logic [63:0]           out_metric_value,
  output logic                  out_last
);

  localparam int NS = (MAX_THREADS < tsta_pkg::SLOT_LIMIT) ? MAX_THREADS
                                                             : tsta_pkg::SLOT_LIMIT;
  localparam int AW = (NS > 1) ? $clog2(NS) : 1;
  localparam int CW = $clog2(NS + 1);
  localparam logic [AW-1:0] LAST_IT = AW'(NS - 1);

  // control state
  tsta_pkg::bstate_t state_r, state_nxt;
  logic [NS-1:0]     slot_reg_r, slot_reg_nxt;
  logic [CW-1:0]     reg_cnt_r, reg_cnt_nxt;
  logic [3:0]        main_slot_r, main_slot_nxt;
  logic              serial_r, serial_nxt;
  logic [2:0]        slot_state_r [NS];
  logic [2:0]        slot_state_nxt [NS];
  logic [AW-1:0]     it_r, it_nxt;
  logic              pass_r, pass_nxt;
  logic [3:0]        k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload state
  tsta_pkg::cmd_t    cmd_r, cmd_nxt;
  tsta_pkg::row_t    row_r, row_nxt;
  logic [63:0]       now_r, now_nxt;
  logic [63:0]       d_r, d_nxt;
  logic [63:0]       diff_r, diff_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [63:0]       minv_r, minv_nxt;
  logic [63:0]       lb_r, lb_nxt;
  logic [63:0]       sched_r, sched_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [6:0][63:0]  acc_r, acc_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [3:0]        oidx_r, oidx_nxt;
  logic [63:0]       oval_r, oval_nxt;
  logic              olast_r, olast_nxt;

  // memory port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  tsta_pkg::row_t    ram_wdata, ram_rdata;

  // shared decode
  logic [AW-1:0]     cs;
  logic              reg_hit, part, it_last, ld_ok;
  logic [2:0]        ti;
  logic [CW-1:0]     cm1;
  logic [3:0]        e_idx;
  logic [63:0]       e_val;
  logic              e_last;
  logic [1:0]        e_status;

  assign cs      = cmd_r.slot[AW-1:0];
  assign reg_hit = cmd_r.in_range && slot_reg_r[cs];
  assign part    = slot_reg_r[it_r] && cmd_r.slot_mask[it_r];
  assign it_last = (it_r == LAST_IT);
  assign ld_ok   = !out_valid_r || out_tready;
  assign cm1     = reg_cnt_r - CW'(1);

  tsta_ram #(
    .WIDTH (tsta_pkg::ROW_W),
    .DEPTH (NS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pick the result for the current emit step
  always_comb begin
    e_idx    = k_r;
    e_val    = 64'd0;
    e_last   = 1'b0;
    e_status = (cmd_r.kind == tsta_pkg::K_AGG_ALL) ? status_r : tsta_pkg::ST_OK;
    if (k_r < 4'd7) begin
      e_val = acc_r[k_r[2:0]];
    end else if (cmd_r.kind == tsta_pkg::K_AGG_ALL) begin
      e_idx  = tsta_pkg::M_CPUS;
      e_val  = 64'(reg_cnt_r);
      e_last = 1'b1;
    end else begin
      case (k_r)
        tsta_pkg::M_LB:    e_val = lb_r;
        tsta_pkg::M_SCHED: e_val = sched_r;
        default: begin
          e_val  = 64'(n_r);
          e_last = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsta_pkg::S_IDLE: begin
        if (q_valid) state_nxt = tsta_pkg::S_DISP;
      end
      tsta_pkg::S_DISP: begin
        case (cmd_r.kind)
          tsta_pkg::K_UPDATE:  state_nxt = reg_hit ? tsta_pkg::S_URD : tsta_pkg::S_ONE;
          tsta_pkg::K_AGG_ALL: state_nxt = reg_hit ? tsta_pkg::S_NOW : tsta_pkg::S_ONE;
          tsta_pkg::K_AGG_SUB: state_nxt = reg_hit ? tsta_pkg::S_NOW : tsta_pkg::S_ONE;
          default:             state_nxt = tsta_pkg::S_ONE;
        endcase
      end
      tsta_pkg::S_URD:  state_nxt = tsta_pkg::S_UADD;
      tsta_pkg::S_UADD: state_nxt = tsta_pkg::S_UWR;
      tsta_pkg::S_UWR:  state_nxt = tsta_pkg::S_ONE;
      tsta_pkg::S_NOW:  state_nxt = tsta_pkg::S_SCAN;
      tsta_pkg::S_SCAN, tsta_pkg::S_AFIN: begin
        if (state_r == tsta_pkg::S_SCAN && part) begin
          state_nxt = tsta_pkg::S_ARD;
        end else if (!it_last) begin
          state_nxt = tsta_pkg::S_SCAN;
        end else if (cmd_r.kind == tsta_pkg::K_AGG_ALL) begin
          state_nxt = tsta_pkg::S_EMIT;
        end else if (!pass_r) begin
          state_nxt = tsta_pkg::S_SCAN;
        end else begin
          state_nxt = tsta_pkg::S_SCHED;
        end
      end
      tsta_pkg::S_ARD:   state_nxt = tsta_pkg::S_AADV;
      tsta_pkg::S_AADV:  state_nxt = tsta_pkg::S_AFIN;
      tsta_pkg::S_SCHED: state_nxt = tsta_pkg::S_EMIT;
      tsta_pkg::S_EMIT: begin
        if (ld_ok && e_last) state_nxt = tsta_pkg::S_IDLE;
      end
      tsta_pkg::S_ONE: begin
        if (ld_ok) state_nxt = tsta_pkg::S_IDLE;
      end
      default: state_nxt = tsta_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_reg_nxt  = slot_reg_r;
    reg_cnt_nxt   = reg_cnt_r;
    main_slot_nxt = main_slot_r;
    serial_nxt    = serial_r;
    slot_state_nxt = slot_state_r;
    it_nxt        = it_r;
    pass_nxt      = pass_r;
    k_nxt         = k_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    now_nxt       = now_r;
    d_nxt         = d_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    minv_nxt      = minv_r;
    lb_nxt        = lb_r;
    sched_nxt     = sched_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    acc_nxt       = acc_r;
    ost_nxt       = ost_r;
    oidx_nxt      = oidx_r;
    oval_nxt      = oval_r;
    olast_nxt     = olast_r;
    out_valid_nxt = out_valid_r && !out_tready;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = it_r;
    ram_raddr     = it_r;
    ram_wdata     = row_r;
    ti            = tsta_pkg::TM_NONE;

    case (state_r)
      tsta_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
        end
      end

      // act on the short commands, start reads for the long ones
      tsta_pkg::S_DISP: begin
        status_nxt = tsta_pkg::ST_OK;
        if (cmd_r.kind == tsta_pkg::K_REG) begin
          if (cmd_r.in_range && !slot_reg_r[cs]) begin
            ram_we              = 1'b1;
            ram_waddr           = cs;
            ram_wdata           = '0;
            ram_wdata.last      = {1'b0, cmd_r.timestamp};
            slot_reg_nxt[cs]    = 1'b1;
            reg_cnt_nxt         = reg_cnt_r + CW'(1);
            slot_state_nxt[cs]  = tsta_pkg::TS_DISABLED;
            if (reg_cnt_r == '0) begin
              main_slot_nxt = cmd_r.slot;
              serial_nxt    = 1'b1;
            end
          end
        end else if (cmd_r.kind != tsta_pkg::K_NOP) begin
          if (!reg_hit) begin
            status_nxt = tsta_pkg::ST_UNREG;
          end else begin
            case (cmd_r.kind)
              tsta_pkg::K_STATE:  slot_state_nxt[cs] = cmd_r.req_state;
              tsta_pkg::K_SERIAL: begin
                if (cmd_r.slot == main_slot_r) serial_nxt = cmd_r.serial_value;
              end
              default: begin
                ram_re    = 1'b1;
                ram_raddr = cs;
              end
            endcase
          end
        end
      end

      // update: elapsed time, charge, extra serial share, counters
      tsta_pkg::S_URD: begin
        row_nxt = ram_rdata;
        d_nxt   = {1'b0, cmd_r.timestamp} - ram_rdata.last;
      end
      tsta_pkg::S_UADD: begin
        ti = tsta_pkg::timer_of(slot_state_r[cs]);
        if (ti != tsta_pkg::TM_NONE) begin
          row_nxt.tm[ti] = row_r.tm[ti] + d_r;
        end
        row_nxt.last = {1'b0, cmd_r.timestamp};
        prod_nxt     = d_r * cm1;
      end
      tsta_pkg::S_UWR: begin
        ram_we    = 1'b1;
        ram_waddr = cs;
        if (slot_state_r[cs] == tsta_pkg::TS_MPI && serial_r
            && cmd_r.slot == main_slot_r) begin
          ram_wdata.tm[tsta_pkg::TM_OMPMPI] = row_r.tm[tsta_pkg::TM_OMPMPI] + prod_r;
        end
        if (hwc_enabled && cmd_r.counters_valid) begin
          ram_wdata.hw[tsta_pkg::HW_CYCLES] = row_r.hw[tsta_pkg::HW_CYCLES]
                                              + 64'(cmd_r.cycles_delta);
          ram_wdata.hw[tsta_pkg::HW_INSTR]  = row_r.hw[tsta_pkg::HW_INSTR]
                                              + 64'(cmd_r.instr_delta);
        end
      end

      // aggregation: take the caller's time and clear the sums
      tsta_pkg::S_NOW: begin
        now_nxt    = ram_rdata.last;
        it_nxt     = '0;
        pass_nxt   = 1'b0;
        k_nxt      = '0;
        acc_nxt    = '0;
        minv_nxt   = tsta_pkg::SIGNED_TOP64;
        n_nxt      = '0;
        lb_nxt     = '0;
        status_nxt = tsta_pkg::ST_OK;
      end
      // fetch the row under the walk pointer
      tsta_pkg::S_SCAN: begin
        ram_re = 1'b1;
      end
      tsta_pkg::S_ARD: begin
        row_nxt  = ram_rdata;
        d_nxt    = now_r - ram_rdata.last;
        diff_nxt = ram_rdata.tm[tsta_pkg::TM_OMPIN] - minv_r;
      end
      tsta_pkg::S_AADV: begin
        if (it_r != cs) begin
          ti = tsta_pkg::timer_of(slot_state_r[it_r]);
          if (ti != tsta_pkg::TM_NONE) begin
            row_nxt.tm[ti] = row_r.tm[ti] + d_r;
          end
          row_nxt.last = now_r;
        end
      end
      tsta_pkg::S_AFIN: begin
        ram_we    = 1'b1;
        ram_waddr = it_r;
        if (cmd_r.kind == tsta_pkg::K_AGG_SUB && !pass_r) begin
          // first pass: keep the advanced row, track the minimum
          if ($signed(row_r.tm[tsta_pkg::TM_OMPIN]) < $signed(minv_r)) begin
            minv_nxt = row_r.tm[tsta_pkg::TM_OMPIN];
          end
          n_nxt = n_r + CW'(1);
        end else begin
          // drain into the sums
          acc_nxt[0] = acc_r[0] + row_r.tm[tsta_pkg::TM_USEFUL];
          acc_nxt[1] = acc_r[1] + row_r.tm[tsta_pkg::TM_MPI];
          acc_nxt[2] = acc_r[2] + row_r.tm[tsta_pkg::TM_OMPMPI];
          acc_nxt[3] = acc_r[3] + row_r.tm[tsta_pkg::TM_OMPOUT];
          acc_nxt[4] = acc_r[4] + row_r.tm[tsta_pkg::TM_GPU];
          acc_nxt[5] = acc_r[5] + row_r.hw[tsta_pkg::HW_CYCLES];
          acc_nxt[6] = acc_r[6] + row_r.hw[tsta_pkg::HW_INSTR];
          ram_wdata.tm[tsta_pkg::TM_USEFUL] = '0;
          ram_wdata.tm[tsta_pkg::TM_MPI]    = '0;
          ram_wdata.tm[tsta_pkg::TM_OMPMPI] = '0;
          ram_wdata.tm[tsta_pkg::TM_OMPOUT] = '0;
          ram_wdata.tm[tsta_pkg::TM_GPU]    = '0;
          ram_wdata.hw                      = '0;
          if (cmd_r.kind == tsta_pkg::K_AGG_ALL) begin
            if (row_r.tm[tsta_pkg::TM_OMPIN] != '0) status_nxt = tsta_pkg::ST_OMPIN;
          end else begin
            lb_nxt = lb_r + diff_r;
            ram_wdata.tm[tsta_pkg::TM_OMPIN] = '0;
          end
        end
      end
      tsta_pkg::S_SCHED: begin
        sched_nxt = minv_r * n_r;
      end

      // emit results through the output register
      tsta_pkg::S_EMIT: begin
        if (ld_ok) begin
          out_valid_nxt = 1'b1;
          ost_nxt       = e_status;
          oidx_nxt      = e_idx;
          oval_nxt      = e_val;
          olast_nxt     = e_last;
          k_nxt         = k_r + 4'd1;
        end
      end
      tsta_pkg::S_ONE: begin
        if (ld_ok) begin
          out_valid_nxt = 1'b1;
          ost_nxt       = status_r;
          oidx_nxt      = tsta_pkg::M_USEFUL;
          oval_nxt      = '0;
          olast_nxt     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // step the slot walk
    if ((state_r == tsta_pkg::S_SCAN && !part) || state_r == tsta_pkg::S_AFIN) begin
      if (!it_last) begin
        it_nxt = it_r + AW'(1);
      end else begin
        it_nxt   = '0;
        pass_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsta_pkg::S_IDLE;
      slot_reg_r   <= '0;
      reg_cnt_r    <= '0;
      main_slot_r  <= '0;
      serial_r     <= 1'b0;
      it_r         <= '0;
      pass_r       <= 1'b0;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        slot_state_r[i] <= tsta_pkg::TS_DISABLED;
      end
    end else begin
      state_r      <= state_nxt;
      slot_reg_r   <= slot_reg_nxt;
      reg_cnt_r    <= reg_cnt_nxt;
      main_slot_r  <= main_slot_nxt;
      serial_r     <= serial_nxt;
      it_r         <= it_nxt;
      pass_r       <= pass_nxt;
      k_r          <= k_nxt;
      out_valid_r  <= out_valid_nxt;
      slot_state_r <= slot_state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    row_r    <= row_nxt;
    now_r    <= now_nxt;
    d_r      <= d_nxt;
    diff_r   <= diff_nxt;
    prod_r   <= prod_nxt;
    minv_r   <= minv_nxt;
    lb_r     <= lb_nxt;
    sched_r  <= sched_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    acc_r    <= acc_nxt;
    ost_r    <= ost_nxt;
    oidx_r   <= oidx_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid       = out_valid_r;
  assign out_status       = ost_r;
  assign out_metric_index = oidx_r;
  assign out_metric_value = oval_r;
  assign out_last         = olast_r;

`ifndef SYNTHESIS
  // registration count follows the registered set
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    reg_cnt_r == CW'($countones(slot_reg_r)))
    else $error("registration count out of step with registered slots");

  // main slot is a registered slot once anything is registered
  a_main: assert property (@(posedge clk) disable iff (!rst_n)
    (reg_cnt_r != '0) |-> slot_reg_r[main_slot_r[AW-1:0]])
    else $error("main slot not registered");

  // memory writes only from the states that own them
  a_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == tsta_pkg::S_DISP || state_r == tsta_pkg::S_UWR
                || state_r == tsta_pkg::S_AFIN))
    else $error("memory write outside a write state");

  // the final aggregate result returns the sequencer to idle
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsta_pkg::S_EMIT && ld_ok && e_last) |=> state_r == tsta_pkg::S_IDLE)
    else $error("sequencer did not finish after final result");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thread state time accounting unit: a queue-fed
// stream driver, a monitor comparing each result transfer against a predicted
// metric queue, APB writes of hwc_enabled between phases, and idle phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [2:0]  req_state;
    logic [62:0] timestamp;
    logic [31:0] cycles_delta;
    logic [31:0] instr_delta;
    logic        counters_valid;
    logic        serial_value;
    logic [15:0] slot_mask;
  } job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  metric;
    logic [63:0] value;
    logic        last;
  } metric_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  thread_state_time_accounting_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0]      acct_reg;
  int unsigned      acct_count;
  logic [3:0]       acct_main;
  logic             acct_serial;
  logic [2:0]       acct_state [16];
  logic [63:0]      acct_last [16];
  logic [63:0]      acct_tm [16][6];
  logic [63:0]      acct_hw [16][2];
  logic             acct_hwc;

  job_t    pending_jobs [$];
  metric_t expected_metrics [$];
  int      fail_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles = 0;
  int      cycle_count = 0;
  logic [63:0] ts_now [16];

  function automatic void charge(int s, logic [63:0] now);
    logic [63:0] d;
    logic [2:0] t;
    d = now - acct_last[s];
    t = tsta_pkg::timer_of(acct_state[s]);
    acct_last[s] = now;
    if (t != tsta_pkg::TM_NONE) acct_tm[s][t] += d;
  endfunction

  function automatic void push_metric(logic [1:0] st, int idx, logic [63:0] v, bit l);
    metric_t m;
    m.status = st; m.metric = idx[3:0]; m.value = v; m.last = l;
    expected_metrics.push_back(m);
  endfunction

  function automatic void drain_slot(int s, ref logic [63:0] acc [10]);
    acc[0] += acct_tm[s][tsta_pkg::TM_USEFUL]; acc[1] += acct_tm[s][tsta_pkg::TM_MPI];
    acc[2] += acct_tm[s][tsta_pkg::TM_OMPMPI]; acc[3] += acct_tm[s][tsta_pkg::TM_OMPOUT];
    acc[4] += acct_tm[s][tsta_pkg::TM_GPU];
    acc[5] += acct_hw[s][0]; acc[6] += acct_hw[s][1];
    acct_tm[s][tsta_pkg::TM_USEFUL] = 0; acct_tm[s][tsta_pkg::TM_MPI] = 0;
    acct_tm[s][tsta_pkg::TM_OMPMPI] = 0;
    acct_tm[s][tsta_pkg::TM_OMPOUT] = 0; acct_tm[s][tsta_pkg::TM_GPU] = 0;
    acct_hw[s][0] = 0; acct_hw[s][1] = 0;
  endfunction

  // work out the metrics caused by one accepted item
  function automatic void predict_metrics(job_t j);
    logic [63:0] acc [10];
    logic [63:0] now, minv, lb, d;
    logic [1:0]  st;
    int s, n;
    s = j.slot;
    for (int k = 0; k < 10; k++) acc[k] = 0;
    if (j.op == tsta_pkg::OP_REGISTER) begin
      if (!acct_reg[s]) begin
        acct_reg[s] = 1'b1; acct_count++;
        acct_last[s] = {1'b0, j.timestamp}; acct_state[s] = tsta_pkg::TS_DISABLED;
        for (int t = 0; t < 6; t++) acct_tm[s][t] = 0;
        acct_hw[s][0] = 0; acct_hw[s][1] = 0;
        if (acct_count == 1) begin
          acct_main = j.slot; acct_serial = 1'b1;
        end
      end
      push_metric(tsta_pkg::ST_OK, 0, 0, 1);
    end else if (j.op > tsta_pkg::OP_AGG_SUBSET) begin
      push_metric(tsta_pkg::ST_OK, 0, 0, 1);
    end else if (!acct_reg[s]) begin
      push_metric(tsta_pkg::ST_UNREG, 0, 0, 1);
    end else if (j.op == tsta_pkg::OP_SET_STATE) begin
      acct_state[s] = j.req_state;
      push_metric(tsta_pkg::ST_OK, 0, 0, 1);
    end else if (j.op == tsta_pkg::OP_SET_SERIAL) begin
      if (j.slot == acct_main) acct_serial = j.serial_value;
      push_metric(tsta_pkg::ST_OK, 0, 0, 1);
    end else if (j.op == tsta_pkg::OP_UPDATE) begin
      d = {1'b0, j.timestamp} - acct_last[s];
      charge(s, {1'b0, j.timestamp});
      if (acct_state[s] == tsta_pkg::TS_MPI && acct_serial && j.slot == acct_main)
        acct_tm[s][tsta_pkg::TM_OMPMPI] += d * 64'(acct_count - 1);
      if (acct_hwc && j.counters_valid) begin
        acct_hw[s][0] += 64'(j.cycles_delta); acct_hw[s][1] += 64'(j.instr_delta);
      end
      push_metric(tsta_pkg::ST_OK, 0, 0, 1);
    end else if (j.op == tsta_pkg::OP_AGG_ALL) begin
      now = acct_last[s]; st = tsta_pkg::ST_OK;
      for (int i = 0; i < 16; i++) begin
        if (!acct_reg[i]) continue;
        if (i != s) charge(i, now);
        if (acct_tm[i][tsta_pkg::TM_OMPIN] != 0) st = tsta_pkg::ST_OMPIN;
        drain_slot(i, acc);
      end
      for (int k = 0; k < 7; k++) push_metric(st, k, acc[k], 0);
      push_metric(st, tsta_pkg::M_CPUS, 64'(acct_count), 1);
    end else begin
      now = acct_last[s]; minv = tsta_pkg::SIGNED_TOP64; n = 0; lb = 0;
      for (int i = 0; i < 16; i++) begin
        if (!acct_reg[i] || !j.slot_mask[i]) continue;
        if (i != s) charge(i, now);
        if ($signed(acct_tm[i][tsta_pkg::TM_OMPIN]) < $signed(minv))
          minv = acct_tm[i][tsta_pkg::TM_OMPIN];
        n++;
      end
      for (int i = 0; i < 16; i++) begin
        if (!acct_reg[i] || !j.slot_mask[i]) continue;
        lb += acct_tm[i][tsta_pkg::TM_OMPIN] - minv;
        acct_tm[i][tsta_pkg::TM_OMPIN] = 0;
        drain_slot(i, acc);
      end
      acc[7] = lb; acc[8] = minv * 64'(n); acc[9] = 64'(n);
      for (int k = 0; k < 10; k++) push_metric(tsta_pkg::ST_OK, k, acc[k], k == 9);
    end
  endfunction

  // driver: offer queued items, advance on each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_metrics(pending_jobs.pop_front());
      if ((!in_tvalid || in_tready) && pending_jobs.size() != 0
          && $urandom_range(99) >= send_idle_pct) begin
        job_t nj;
        nj = pending_jobs[0];
        in_tvalid <= 1'b1;
        in_tuser  <= nj.op;
        in_tdata  <= {nj.slot_mask, nj.serial_value, nj.counters_valid, nj.instr_delta,
                      nj.cycles_delta, nj.timestamp, nj.req_state, nj.slot};
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer, then choose the next ready
  always @(posedge clk) begin
    metric_t e;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_tvalid && out_tready) begin
        if (expected_metrics.size() == 0) begin
          $error("unexpected result metric %0d", out_tuser);
          fail_count++;
        end else begin
          e = expected_metrics.pop_front();
          if (out_tdata[1:0] !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_tdata[1:0]); fail_count++;
          end
          if (out_tuser !== e.metric) begin
            $error("metric_index exp %0d got %0d", e.metric, out_tuser); fail_count++;
          end
          if (out_tdata[65:2] !== e.value) begin
            $error("metric_value exp %0h got %0h", e.value, out_tdata[65:2]); fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast); fail_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (cycle_count > 2000000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    acct_hwc = v[0];
  endtask

  task automatic wait_drained();
    while (pending_jobs.size() != 0 || in_tvalid || expected_metrics.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [62:0] rand_ts();
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    return v;
  endfunction

  function automatic job_t make_job(logic [2:0] op, logic [3:0] s);
    job_t j;
    j.op = op; j.slot = s; j.req_state = 3'($urandom_range(7));
    j.timestamp = rand_ts(); j.cycles_delta = $urandom; j.instr_delta = $urandom;
    j.counters_valid = 1'($urandom_range(1)); j.serial_value = 1'($urandom_range(1));
    j.slot_mask = 16'($urandom);
    return j;
  endfunction

  // mostly well-formed traffic: valid states, rising time per slot
  function automatic job_t rand_job();
    job_t j;
    int r;
    r = $urandom_range(99);
    j = make_job(tsta_pkg::OP_REGISTER, 4'($urandom_range(15)));
    if (r < 8) j.op = tsta_pkg::OP_REGISTER;
    else if (r < 28) j.op = tsta_pkg::OP_SET_STATE;
    else if (r < 33) j.op = tsta_pkg::OP_SET_SERIAL;
    else if (r < 73) j.op = tsta_pkg::OP_UPDATE;
    else if (r < 83) j.op = tsta_pkg::OP_AGG_ALL;
    else if (r < 95) j.op = tsta_pkg::OP_AGG_SUBSET;
    else j.op = 3'($urandom_range(6, 7));
    if ($urandom_range(9) != 0) begin
      if (j.req_state > tsta_pkg::TS_GPU) j.req_state = 3'($urandom_range(5));
      if (j.op == tsta_pkg::OP_UPDATE) begin
        ts_now[j.slot] += 64'($urandom_range(100000));
        j.timestamp = ts_now[j.slot][62:0];
      end else if (j.op == tsta_pkg::OP_REGISTER) begin
        j.timestamp = ts_now[j.slot][62:0];
      end
    end
    return j;
  endfunction

  initial begin
    job_t j;
    acct_reg = 0; acct_count = 0; acct_main = 0; acct_serial = 0; acct_hwc = 0;
    for (int i = 0; i < 16; i++) begin
      acct_state[i] = tsta_pkg::TS_DISABLED; acct_last[i] = 0;
      for (int t = 0; t < 6; t++) acct_tm[i][t] = 0;
      acct_hw[i][0] = 0; acct_hw[i][1] = 0;
      ts_now[i] = 64'($urandom_range(1000));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    apb_write(32'd1);

    // directed: unregistered caller, unknown op, registration, states, aggregations
    pending_jobs.push_back(make_job(tsta_pkg::OP_UPDATE, 4'd3));
    pending_jobs.push_back(make_job(tsta_pkg::OP_AGG_ALL, 4'd3));
    pending_jobs.push_back(make_job(3'd7, 4'd0));
    j = make_job(tsta_pkg::OP_REGISTER, 4'd0); j.timestamp = 63'd0;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_REGISTER, 4'd15); j.timestamp = 63'd10;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_REGISTER, 4'd0); j.timestamp = 63'd99;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_SET_STATE, 4'd0); j.req_state = tsta_pkg::TS_MPI;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_UPDATE, 4'd0); j.timestamp = 63'd500; j.counters_valid = 1;
    j.cycles_delta = '1; j.instr_delta = '1; pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_SET_SERIAL, 4'd15); j.serial_value = 0;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_SET_STATE, 4'd15); j.req_state = tsta_pkg::TS_OMPIN;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_UPDATE, 4'd15); j.timestamp = 63'd700;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_AGG_ALL, 4'd0); pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_AGG_SUBSET, 4'd0); j.slot_mask = 16'h0000;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_SET_STATE, 4'd0); j.req_state = 3'd6;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_UPDATE, 4'd0); j.timestamp = '1; pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_SET_SERIAL, 4'd0); j.serial_value = 0;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_AGG_SUBSET, 4'd15); j.slot_mask = 16'hFFFF;
    pending_jobs.push_back(j);
    j = make_job(tsta_pkg::OP_AGG_ALL, 4'd15); pending_jobs.push_back(j);
    ts_now[0] = 64'h7FFF_FFFF_FFFF_FFFF; ts_now[15] = 64'd1000;
    wait_drained();

    // random phases with changing idling and counter enable
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 23 : 0;
      apb_write({31'd0, ph[0] == 1'b0});
      for (int n = 0; n < 130; n++) pending_jobs.push_back(rand_job());
      if (ph == 2) begin
        hold_cycles = 400;
        while (pending_jobs.size() > 70) @(posedge clk);
        // let the sender drain the queue until every result is in
        wait_drained();
        for (int n = 0; n < 20; n++) pending_jobs.push_back(rand_job());
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[sim.f]
sv/tsta_pkg.sv
sv/tsta_ram.sv
sv/tsta_front.sv
sv/tsta_back.sv
sv/thread_state_time_accounting_unit.sv
tb/sv/tb.sv
